FILE: design/assert_macros.svh
// Assertion macros for the checker file of the waveform generator.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, held off while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

FILE: design/sswg_pkg.sv
// Package of the square/sine/sawtooth waveform generator: widths, codes,
// level constants and the build-time sine table. Depends on nothing.
package sswg_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int MODE_W     = 2;
  localparam int DUTY_W     = 7;
  localparam int FREQ_W     = 14;
  localparam int INTERVAL_W = 16;
  localparam int STEP_W     = 9;
  localparam int DAC_W      = 12;
  localparam int ROM_DEPTH  = 512;
  localparam int DIV_W      = 18;
  localparam int DIV_CNT_W  = 5;

  localparam logic [DAC_W-1:0]      HIGH_LEVEL     = 12'd3760;
  localparam logic [DAC_W-1:0]      SAW_STEP       = 12'd10;
  localparam logic [DIV_W-1:0]      BASE_SQUARE    = 18'd238000;
  localparam logic [DIV_W-1:0]      BASE_SINE      = 18'd76500;
  localparam logic [DIV_W-1:0]      BASE_SAW       = 18'd96700;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 16'hFFFF;
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd2380;
  localparam logic [DUTY_W-1:0]     RESET_DUTY     = 7'd50;
  localparam logic [FREQ_W-1:0]     RESET_FREQ     = 14'd100;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 2'd0,
    REG_DUTY = 2'd1,
    REG_FREQ = 2'd2
  } reg_idx_t;

  // Waveform modes; the fourth code is unused
  typedef enum logic [MODE_W-1:0] {
    MODE_SQUARE = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SAW    = 2'd2
  } mode_t;

  // Level update carried from the tick stage to the level stage
  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_HIGH,
    ACT_LOW,
    ACT_ROM,
    ACT_SAW
  } action_t;

  typedef struct packed {
    action_t act;
    logic    fire;
  } stage_t;

  typedef logic [DAC_W-1:0] sine_tab_t [ROM_DEPTH];

  localparam logic [63:0] Q_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] Q_PI      = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] Q_HALF_PI = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] Q_TWO_PI  = 64'h6487_ED51_10B4_611A;

  // (a*b) >> 60 on unsigned Q60 values, from four 32x32 partial products
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, {32'd0, a[63:32]} * {32'd0, b[63:32]}} << 64)
      + ({64'd0, {32'd0, a[31:0]} * {32'd0, b[63:32]}} << 32)
      + ({64'd0, {32'd0, a[63:32]} * {32'd0, b[31:0]}} << 32)
      + {64'd0, {32'd0, a[31:0]} * {32'd0, b[31:0]}};
    return p[123:60];
  endfunction

  // i/50 rounded to a 24-bit significand, ties to even, as Q60
  function automatic logic [63:0] angle_q60(input int unsigned i);
    int unsigned s;
    logic [63:0] q;
    logic [63:0] r;
    s = 0;
    if (i == 0) return 64'd0;
    while (s < 40 && (((64'(i) << s) / 50) < (64'd1 << 23))) s++;
    q = (64'(i) << s) / 50;
    r = (64'(i) << s) % 50;
    if (2 * r > 50 || (2 * r == 50 && q[0])) q = q + 64'd1;
    return q << (60 - s);
  endfunction

  // DAC code of one sine table entry, Taylor series in Q60
  function automatic logic [DAC_W-1:0] sine_code(input int unsigned i);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] onep;
    logic [63:0] v;
    logic        neg;
    x   = angle_q60(i);
    neg = 1'b0;
    while (x >= Q_TWO_PI) x = x - Q_TWO_PI;
    if (x <= Q_HALF_PI) begin
      y = x;
    end else if (x <= Q_PI) begin
      y = Q_PI - x;
    end else if (x <= Q_PI + Q_HALF_PI) begin
      y   = x - Q_PI;
      neg = 1'b1;
    end else begin
      y   = Q_TWO_PI - x;
      neg = 1'b1;
    end
    y2   = qmul(y, y);
    term = y;
    acc  = y;
    for (int n = 1; n <= 12; n++) begin
      term = qmul(term, y2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc > Q_ONE) acc = Q_ONE;
    onep = neg ? Q_ONE - acc : Q_ONE + acc;
    v = (((onep >> 20) * 64'd61440) / 33) >> 40;
    return (v > 64'd4095) ? 12'hFFF : v[DAC_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i < ROM_DEPTH; i++) tab[i] = sine_code(i);
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

FILE: design/square_sine_sawtooth_waveform_generator.sv
// Top level of the square/sine/sawtooth waveform generator: tick stage,
// sine ROM with registered read, level stage and interval divider.
// Depends on sswg_pkg.
//
//   channel  signals                                  beat
//   cfg      cfg_we, cfg_index, cfg_data              one register write
//   in       in_valid, in_ready, tick                 one timebase tick
//   out      out_valid, out_ready, dac_code,          one level and step flag
//            sample_update
//
// One tick is taken per cycle unless the divider runs or the output stalls;
// its result passes the tick stage register and then the output register.
// A register write with a nonzero frequency in a defined mode runs the
// restoring divider, one quotient bit a cycle, with in_ready low.
// Reset is synchronous; it restores the reset configuration and interval.
// A stalled output holds its beat; in_ready is high while the divider is idle
// and the tick stage is empty or can hand its beat on.
module square_sine_sawtooth_waveform_generator #(
  parameter int SINE_STEPS   = 314,
  parameter int SQUARE_SLOTS = 100
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sswg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sswg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sswg_pkg::DAC_W-1:0]      dac_code,
  output logic                            sample_update
);
  import sswg_pkg::*;

  localparam logic [STEP_W-1:0] SLOTS = STEP_W'(SQUARE_SLOTS);
  localparam logic [STEP_W:0]   STEPS = (STEP_W + 1)'(SINE_STEPS);

  // Configuration and waveform state
  logic [MODE_W-1:0]     waveform_mode;
  logic [DUTY_W-1:0]     duty_percent;
  logic [FREQ_W-1:0]     frequency_hz;
  logic [INTERVAL_W-1:0] sample_interval;
  logic [INTERVAL_W-1:0] tick_count;
  logic [STEP_W-1:0]     step_index;
  logic [DAC_W-1:0]      output_level;

  // Divider
  logic                  div_busy;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIV_W-1:0]      div_quot;
  logic [FREQ_W-1:0]     div_rem;
  logic [FREQ_W-1:0]     div_dvs;

  // Pipeline
  logic                  s1_valid;
  stage_t                s1;
  logic [DAC_W-1:0]      rom_q;

  // Combinational
  logic                  accept;
  logic                  s1_adv;
  logic                  cfg_hit;
  logic [MODE_W-1:0]     mode_new;
  logic [FREQ_W-1:0]     freq_new;
  logic [DIV_W-1:0]      base_new;
  logic                  base_ok;
  logic [INTERVAL_W-1:0] tick_inc;
  logic                  fire;
  logic [STEP_W-1:0]     duty_lim;
  logic [STEP_W-1:0]     step_next;
  action_t               act;
  logic [DAC_W-1:0]      saw_sum;
  logic [DAC_W-1:0]      level_next;
  logic [FREQ_W:0]       div_sh;
  logic                  div_ge;
  logic [FREQ_W-1:0]     div_rem_next;
  logic [DIV_W-1:0]      div_quot_next;
  logic                  div_last;
  logic [INTERVAL_W-1:0] div_sat;

  // Handshake
  assign accept    = in_valid && in_ready;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !div_busy && (!s1_valid || s1_adv);
  assign dac_code  = output_level;

  // Decode a register write and pick the interval base of the new mode
  always_comb begin
    cfg_hit  = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_DUTY ||
                          cfg_index == REG_FREQ);
    mode_new = (cfg_we && cfg_index == REG_MODE) ? cfg_data[MODE_W-1:0] : waveform_mode;
    freq_new = (cfg_we && cfg_index == REG_FREQ) ? cfg_data[FREQ_W-1:0] : frequency_hz;
    base_ok  = 1'b1;
    case (mode_new)
      MODE_SQUARE: base_new = BASE_SQUARE;
      MODE_SINE:   base_new = BASE_SINE;
      MODE_SAW:    base_new = BASE_SAW;
      default: begin
        base_new = '0;
        base_ok  = 1'b0;
      end
    endcase
  end

  // One restoring divide step
  always_comb begin
    div_sh        = {div_rem, div_quot[DIV_W-1]};
    div_ge        = div_sh >= {1'b0, div_dvs};
    div_rem_next  = div_ge ? FREQ_W'(div_sh - {1'b0, div_dvs}) : div_sh[FREQ_W-1:0];
    div_quot_next = {div_quot[DIV_W-2:0], div_ge};
    div_last      = div_cnt == DIV_CNT_W'(DIV_W - 1);
    div_sat       = (div_quot_next[DIV_W-1:INTERVAL_W] != '0) ? INTERVAL_MAX :
                    div_quot_next[INTERVAL_W-1:0];
  end

  // Tick stage: count, fire, advance the step index, choose the level update
  always_comb begin
    tick_inc  = tick_count + INTERVAL_W'(1);
    fire      = tick && (tick_inc >= sample_interval);
    duty_lim  = ({2'b00, duty_percent} > SLOTS) ? SLOTS : {2'b00, duty_percent};
    step_next = step_index;
    act       = ACT_HOLD;
    if (fire) begin
      case (waveform_mode)
        MODE_SQUARE: begin
          if (step_index < duty_lim) begin
            act       = ACT_HIGH;
            step_next = step_index + STEP_W'(1);
          end else if (step_index < SLOTS) begin
            act       = ACT_LOW;
            step_next = step_index + STEP_W'(1);
          end else begin
            step_next = '0;
          end
        end
        MODE_SINE: begin
          if ({1'b0, step_index} < STEPS) begin
            act       = ACT_ROM;
            step_next = step_index + STEP_W'(1);
          end else begin
            step_next = '0;
          end
        end
        MODE_SAW: act = ACT_SAW;
        default: ;
      endcase
    end
  end

  // Level stage: apply the update to the output level
  always_comb begin
    saw_sum = output_level + SAW_STEP;
    case (s1.act)
      ACT_HIGH: level_next = HIGH_LEVEL;
      ACT_LOW:  level_next = '0;
      ACT_ROM:  level_next = rom_q;
      ACT_SAW:  level_next = (saw_sum >= HIGH_LEVEL) ? '0 : saw_sum;
      default:  level_next = output_level;
    endcase
  end

  // Control state: configuration, divider, counters, valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_mode   <= MODE_SQUARE;
      duty_percent    <= RESET_DUTY;
      frequency_hz    <= RESET_FREQ;
      sample_interval <= RESET_INTERVAL;
      tick_count      <= '0;
      step_index      <= '0;
      output_level    <= '0;
      div_busy        <= 1'b0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_hit) begin
        case (cfg_index)
          REG_MODE: waveform_mode <= cfg_data[MODE_W-1:0];
          REG_DUTY: duty_percent  <= cfg_data[DUTY_W-1:0];
          REG_FREQ: frequency_hz  <= cfg_data[FREQ_W-1:0];
          default: ;
        endcase
        tick_count <= '0;
        // Restart the interval; a zero frequency saturates at once
        if (base_ok) begin
          if (freq_new == '0) begin
            sample_interval <= INTERVAL_MAX;
            div_busy        <= 1'b0;
          end else begin
            div_busy <= 1'b1;
          end
        end
      end else begin
        if (div_busy && div_last) begin
          div_busy        <= 1'b0;
          sample_interval <= div_sat;
        end
        // Count only real ticks; an idle beat leaves the counter alone
        if (accept) begin
          if (tick) tick_count <= fire ? '0 : tick_inc;
          step_index <= step_next;
        end
      end

      // Hand the beat from the tick stage to the level stage
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;

      if (s1_adv) begin
        out_valid    <= 1'b1;
        output_level <= level_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: divider datapath, stage register, ROM read, step flag
  always_ff @(posedge clk) begin
    if (cfg_hit && base_ok && freq_new != '0) begin
      div_cnt  <= '0;
      div_quot <= base_new;
      div_rem  <= '0;
      div_dvs  <= freq_new;
    end else if (div_busy) begin
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
      div_quot <= div_quot_next;
      div_rem  <= div_rem_next;
    end
    if (accept) begin
      s1.act  <= act;
      s1.fire <= fire;
      rom_q   <= SINE_TAB[step_index];
    end
    if (s1_adv) sample_update <= s1.fire;
  end

endmodule

FILE: design/sswg_chk.sv
// Port-level checker of the waveform generator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module sswg_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] dac_code,
  input logic        sample_update
);

  // Hold a stalled output beat
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(dac_code) && $stable(sample_update))

  // A new output beat comes from a tick that passed the tick stage register and then the output register
  `ASSERT_IMPLY(a_out_from_tick, clk, rst, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Every accepted tick finds an output beat waiting after the tick stage and output registers
  `ASSERT_NEXT(a_tick_to_out, clk, rst, in_valid && in_ready, ##1 out_valid)

endmodule

bind square_sine_sawtooth_waveform_generator sswg_chk u_sswg_chk (.*);

FILE: tb/sv/tb_square_sine_sawtooth_waveform_generator.sv
// Self-checking testbench of the square/sine/sawtooth waveform generator: a tick
// driver, a result checker against a cycle-free model of the level logic, and
// register writes between drained phases. Depends on sswg_pkg and the top level.
module tb_square_sine_sawtooth_waveform_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import sswg_pkg::*;

  localparam int SINE_LEN = 314;
  localparam int SLOTS    = 100;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;

  localparam logic [DAC_W-1:0] LEVEL_HIGH  = 12'd3760;
  localparam logic [DAC_W-1:0] SAW_INC     = 12'd10;
  localparam logic [17:0]      SQUARE_BASE = 18'd238000;
  localparam logic [17:0]      SINE_BASE   = 18'd76500;
  localparam logic [17:0]      SAW_BASE    = 18'd96700;

  localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487_ED51_10B4_611A;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int unsigned TARGET_ITEMS   = 1850;
  localparam int unsigned ITEM_CAP       = 5000;

  typedef struct packed {
    logic [DAC_W-1:0] code;
    logic             fired;
  } dac_beat_t;

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  tick = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DAC_W-1:0]      dac_code;
  logic                  sample_update;

  // Generator model state
  logic [MODE_W-1:0]     cfg_mode;
  logic [DUTY_W-1:0]     cfg_duty;
  logic [FREQ_W-1:0]     cfg_freq;
  logic [15:0]           interval;
  logic [15:0]           ticks_seen;
  logic [8:0]            step_pos;
  logic [DAC_W-1:0]      level_now;
  logic [DAC_W-1:0]      sine_lut [SINE_LEN];
  bit                    sine_wrapped;
  bit                    square_rewound;
  bit                    saw_cleared;

  // Traffic and bookkeeping
  bit        tick_fifo[$];
  dac_beat_t dac_expect_q[$];
  int        ticks_owed;
  bit        in_taken;
  int        send_gap_pct;
  int        recv_stall_pct;
  int        idle_cycles;
  int        mismatches;
  int        ticks_taken;
  int        steps_fired;
  int        beats_checked;
  int        writes_done;

  square_sine_sawtooth_waveform_generator #(
    .SINE_STEPS  (SINE_LEN),
    .SQUARE_SLOTS(SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .tick         (tick),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_code     (dac_code),
    .sample_update(sample_update)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // (a*b) >> 60 on unsigned Q60 operands
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // DAC code of sine table entry idx: angle idx/50 in single precision, sine by series
  function automatic logic [DAC_W-1:0] sine_dac(input int unsigned idx);
    int unsigned sh;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] onep;
    logic [63:0] v;
    logic        neg;
    x   = 64'd0;
    neg = 1'b0;
    sh  = 0;
    if (idx != 0) begin
      // round idx/50 to a 24-bit significand, ties to even
      while (sh < 40 && ((64'(idx) << sh) / 64'd50) < (64'd1 << 23)) sh++;
      num = 64'(idx) << sh;
      q   = num / 64'd50;
      r   = num % 64'd50;
      if (2 * r > 50 || (2 * r == 50 && q[0])) q = q + 64'd1;
      x = q << (60 - sh);
    end
    // fold into the first quadrant
    while (x >= TWO_PI_Q60) x = x - TWO_PI_Q60;
    if (x <= HALF_PI_Q60) begin
      y = x;
    end else if (x <= PI_Q60) begin
      y = PI_Q60 - x;
    end else if (x <= PI_Q60 + HALF_PI_Q60) begin
      y   = x - PI_Q60;
      neg = 1'b1;
    end else begin
      y   = TWO_PI_Q60 - x;
      neg = 1'b1;
    end
    y2   = q60_mul(y, y);
    term = y;
    acc  = y;
    for (int n = 1; n <= 12; n++) begin
      term = q60_mul(term, y2) / 64'((2 * n) * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    if (acc > ONE_Q60) acc = ONE_Q60;
    onep = neg ? ONE_Q60 - acc : ONE_Q60 + acc;
    v = (((onep >> 20) * 64'd61440) / 64'd33) >> 40;
    return (v > 64'd4095) ? 12'hFFF : v[DAC_W-1:0];
  endfunction

  // Rebuild the tick interval from mode and frequency; the spare mode keeps it
  function automatic void recompute_interval();
    logic [17:0] base;
    logic [17:0] quo;
    case (cfg_mode)
      MODE_SQUARE: base = SQUARE_BASE;
      MODE_SINE:   base = SINE_BASE;
      MODE_SAW:    base = SAW_BASE;
      default:     return;
    endcase
    quo = (cfg_freq == '0) ? 18'h3FFFF : base / cfg_freq;
    interval = (quo > 18'd65535) ? 16'hFFFF : quo[15:0];
  endfunction

  function automatic void model_reset();
    cfg_mode   = MODE_SQUARE;
    cfg_duty   = 7'd50;
    cfg_freq   = 14'd100;
    ticks_seen = '0;
    step_pos   = '0;
    level_now  = '0;
    recompute_interval();
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MODE: cfg_mode = data[MODE_W-1:0];
      REG_DUTY: cfg_duty = data[DUTY_W-1:0];
      REG_FREQ: cfg_freq = data[FREQ_W-1:0];
      default:  return;
    endcase
    recompute_interval();
    ticks_seen = '0;
  endfunction

  // Advance the model by one beat and return the level and step flag it shows
  function automatic dac_beat_t step_waveform(input logic tick_in);
    logic [DUTY_W-1:0] duty_cap;
    dac_beat_t         beat;
    beat.fired = 1'b0;
    if (tick_in) begin
      ticks_seen = ticks_seen + 16'd1;
      if (ticks_seen >= interval) begin
        ticks_seen = '0;
        beat.fired = 1'b1;
        steps_fired++;
        duty_cap = (cfg_duty > SLOTS) ? 7'(SLOTS) : cfg_duty;
        case (cfg_mode)
          MODE_SQUARE: begin
            if (step_pos < duty_cap) begin
              level_now = LEVEL_HIGH;
              step_pos++;
            end else if (step_pos < SLOTS) begin
              level_now = '0;
              step_pos++;
            end else begin
              step_pos       = '0;
              square_rewound = 1'b1;
            end
          end
          MODE_SINE: begin
            if (step_pos < SINE_LEN) begin
              level_now = sine_lut[step_pos];
              step_pos++;
            end else begin
              step_pos     = '0;
              sine_wrapped = 1'b1;
            end
          end
          MODE_SAW: begin
            level_now = level_now + SAW_INC;
            if (level_now >= LEVEL_HIGH) begin
              level_now   = '0;
              saw_cleared = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    beat.code = level_now;
    return beat;
  endfunction

  // Tick driver: hold a beat until taken, then maybe leave a gap; also set out_ready at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (tick_fifo.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          tick     <= tick_fifo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: predict on each tick beat, check each result beat, watch for hangs
  always @(posedge clk) begin
    dac_beat_t want;
    if (rst) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        dac_expect_q.push_back(step_waveform(tick));
        ticks_owed--;
        ticks_taken++;
      end
      if (out_valid && out_ready) begin
        beats_checked++;
        if (dac_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result beat with nothing expected: dac_code %0d sample_update %0b",
                     dac_code, sample_update);
        end else begin
          want = dac_expect_q.pop_front();
          if (dac_code !== want.code || sample_update !== want.fired) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: beat %0d: dac_code %0d exp %0d, sample_update %0b exp %0b",
                       beats_checked, dac_code, want.code, sample_update, want.fired);
          end
        end
      end
      if (in_taken || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_square_sine_sawtooth_waveform_generator NOT OK");
        $finish;
      end
    end
  end

  // Register write while idle; wait for the interval divider to release the input
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, data);
    writes_done++;
    repeat (2) @(negedge clk);
    while (!in_ready) @(negedge clk);
  endtask

  // Queue count ticks (pct percent set), then hold off until every result is back
  task automatic feed_ticks(input int unsigned count, input int unsigned pct);
    @(posedge clk);
    repeat (count) tick_fifo.push_back($urandom_range(99) < pct);
    ticks_owed += count;
    do begin
      @(negedge clk);
    end while (ticks_owed != 0 || dac_expect_q.size() != 0);
  endtask

  task automatic set_idling(input int unsigned phase);
    case (phase)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
      default: begin send_gap_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    int unsigned pick;
    pick = $urandom_range(99);
    if (!sine_wrapped) begin
      // keep the sine interval at its shortest so the table gets walked end to end
      return (pick < 90) ? FREQ_W'($urandom_range(15301, 16383))
                         : FREQ_W'($urandom_range(16383));
    end
    if (pick < 70) return FREQ_W'($urandom_range(12000, 16383));
    if (pick < 85) return FREQ_W'($urandom_range(100, 11999));
    case ($urandom_range(6))
      0: return 14'd0;
      1: return 14'd1;
      2: return 14'd2;
      3: return 14'd3;
      4: return 14'd4;
      5: return 14'd10000;
      default: return 14'h3FFF;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_duty();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(4))
        0: return 14'd0;
        1: return 14'd1;
        2: return 14'd99;
        3: return 14'd100;
        default: return 14'd127;
      endcase
    end
    // upper bits are junk the register must drop
    return CFG_DATA_W'($urandom_range(16383));
  endfunction

  initial begin
    int unsigned       seg;
    int unsigned       seg_len;
    int unsigned       tick_pct;
    int unsigned       pick;
    int unsigned       random_items;
    logic [MODE_W-1:0] seg_mode;
    logic [CFG_DATA_W-1:0] mode_data;

    for (int i = 0; i < SINE_LEN; i++) sine_lut[i] = sine_dac(i);
    model_reset();
    set_idling(0);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset setup, shortest intervals, duty above the slot count,
    // spare mode and spare register index, frequency saturation
    feed_ticks(1, 0);
    feed_ticks(1, 100);
    write_reg(REG_FREQ, 14'h3FFF);
    write_reg(REG_DUTY, 14'h3FFF);
    feed_ticks(14, 100);
    write_reg(REG_MODE, 14'(MODE_SINE));
    feed_ticks(1, 0);
    feed_ticks(4, 100);
    write_reg(REG_MODE, 14'(MODE_SPARE));
    write_reg(REG_FREQ, 14'd3);
    feed_ticks(4, 100);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(16383)));
    write_reg(REG_MODE, 14'(MODE_SAW));
    write_reg(REG_FREQ, 14'd0);
    write_reg(REG_FREQ, 14'd1);
    feed_ticks(2, 100);

    // Random phases: steer the mode toward table wrap, slot rewind and sawtooth clear
    random_items = 0;
    seg = 0;
    while ((random_items < TARGET_ITEMS || !sine_wrapped || !square_rewound || !saw_cleared)
           && random_items < ITEM_CAP) begin
      pick = $urandom_range(99);
      if (!sine_wrapped) begin
        seg_mode = (pick < 90) ? MODE_SINE : MODE_SAW;
      end else if (!square_rewound && step_pos >= SLOTS) begin
        seg_mode = MODE_SQUARE;
      end else if (!saw_cleared && level_now >= 12'd3700) begin
        seg_mode = MODE_SAW;
      end else if (!square_rewound) begin
        seg_mode = (pick < 70) ? MODE_SINE : MODE_SQUARE;
      end else if (pick < 35) begin
        seg_mode = MODE_SQUARE;
      end else if (pick < 65) begin
        seg_mode = MODE_SINE;
      end else if (pick < 92) begin
        seg_mode = MODE_SAW;
      end else begin
        seg_mode = MODE_SPARE;
      end
      mode_data = 14'(seg_mode);
      if ($urandom_range(99) < 25) mode_data = mode_data | (14'($urandom) & 14'h3FFC);

      // mode and frequency in either order, duty and the spare index now and then
      if ($urandom_range(99) < 30) begin
        write_reg(REG_FREQ, pick_freq());
        write_reg(REG_MODE, mode_data);
      end else begin
        write_reg(REG_MODE, mode_data);
        if ($urandom_range(99) < 85) write_reg(REG_FREQ, pick_freq());
      end
      if ($urandom_range(99) < 50) write_reg(REG_DUTY, pick_duty());
      if ($urandom_range(99) < 8) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(16383)));

      seg_len  = $urandom_range(40, 120);
      tick_pct = ($urandom_range(99) < 80) ? 95 : $urandom_range(20, 90);
      set_idling(seg % 4);
      feed_ticks(seg_len, tick_pct);
      random_items += seg_len;
      seg++;
    end

    // Let any stray result beat show up before the verdict
    repeat (10) @(negedge clk);
    if (dac_expect_q.size() != 0) begin
      mismatches += dac_expect_q.size();
      $display("ERROR: %0d expected result beats never arrived", dac_expect_q.size());
    end
    $display("Checked %0d result beats from %0d ticks (%0d waveform steps) over %0d writes.",
             beats_checked, ticks_taken, steps_fired, writes_done);
    $display("Sine table wrap %0s, square slot rewind %0s, sawtooth clear %0s.",
             sine_wrapped ? "seen" : "missed", square_rewound ? "seen" : "missed",
             saw_cleared ? "seen" : "missed");
    if (mismatches == 0) begin
      $display("tb_square_sine_sawtooth_waveform_generator OK");
    end else begin
      $display("tb_square_sine_sawtooth_waveform_generator NOT OK");
    end
    $finish;
  end

endmodule
